// ===== rtl/picud_pkg.sv =====
package picud_pkg;

  // Event kinds carried by each input word
  typedef enum logic [1:0] {
    REQ_CPU_WRITE = 2'd0,
    REQ_CPU_CYCLE = 2'd1,
    REQ_A12_RISE  = 2'd2,
    REQ_PPU_READ  = 2'd3
  } req_kind_t;

  // Timer register numbers
  typedef enum logic [2:0] {
    REG_ENABLE   = 3'd0,
    REG_MODE     = 3'd1,
    REG_DISABLE  = 3'd2,
    REG_ENABLE_B = 3'd3,
    REG_PRESCALE = 3'd4,
    REG_COUNTER  = 3'd5,
    REG_XOR_KEY  = 3'd6,
    REG_SIZE     = 3'd7
  } reg_code_t;

  // Prescaler clock source codes, mode bits 1:0
  localparam logic [1:0] SRC_CPU_CYCLE = 2'd0;
  localparam logic [1:0] SRC_A12_RISE  = 2'd1;
  localparam logic [1:0] SRC_PPU_READ  = 2'd2;
  localparam logic [1:0] SRC_CPU_WRITE = 2'd3;

  // Count direction codes, mode bits 7:6
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  // Mode bit positions
  localparam int unsigned MODE_FREEZE_BIT = 3;
  localparam int unsigned MODE_SHORT_BIT  = 2;

  // Prescaler masks and reset values
  localparam logic [7:0] MASK_SHORT     = 8'h07;
  localparam logic [7:0] MASK_LONG      = 8'hFF;
  localparam logic [7:0] PRESCALE_RESET = 8'hFF;
  localparam logic [7:0] COUNT_UP_HIT   = 8'h00;
  localparam logic [7:0] COUNT_DOWN_HIT = 8'hFF;

endpackage

// ===== rtl/picud_if.sv =====
// Event channel: one timer event per word
interface picud_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic       hits_timer_regs;
  logic [2:0] reg_index;
  logic [7:0] write_value;

  modport source (output valid, req_type, hits_timer_regs, reg_index, write_value,
                  input ready);
  modport sink (input valid, req_type, hits_timer_regs, reg_index, write_value,
                output ready);
endinterface

// Result channel: timer state after each event
interface picud_out_if;
  logic       valid;
  logic       ready;
  logic       irq_out;
  logic [7:0] count_now;
  logic [7:0] prescaler_now;

  modport source (output valid, irq_out, count_now, prescaler_now, input ready);
  modport sink (input valid, irq_out, count_now, prescaler_now, output ready);
endinterface

// ===== rtl/prescaled_irq_counter_up_down.sv =====
// The result word for an event is registered and on rsp the cycle after it is taken.
// Throughput: one event per cycle unless a held result stalls req; the timer update
// is an 8-bit increment or decrement and compare, feeding the state and result registers.
// A held result stalls req only when rsp is not ready and the result register is full.
// Reset (rst, synchronous): timer disabled, mode 0, prescaler 0xFF with 3-bit mask,
// counter, key, size and pending interrupt cleared, no result held.
module prescaled_irq_counter_up_down (
  input  logic        clk,
  input  logic        rst,
  picud_in_if.sink    req,
  picud_out_if.source rsp
);
  import picud_pkg::*;

  // Timer state
  logic       enabled;
  logic [7:0] mode_bits;
  logic [7:0] prescale_value;
  logic       mask_short;
  logic [7:0] counter_value;
  logic [7:0] xor_key;
  logic [7:0] size_byte;
  logic       irq_pending;

  logic       enabled_next;
  logic [7:0] mode_bits_next;
  logic [7:0] prescale_value_next;
  logic       mask_short_next;
  logic [7:0] counter_value_next;
  logic [7:0] xor_key_next;
  logic [7:0] size_byte_next;
  logic       irq_pending_next;

  // Result register
  logic       out_valid;
  logic       out_irq;
  logic [7:0] out_count;
  logic [7:0] out_prescale;

  logic       accept;
  logic       clk_match;
  logic [7:0] mask;
  logic [1:0] src;
  logic [1:0] dir;

  // Take a new word whenever the result register is empty or draining
  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign mask = mask_short ? MASK_SHORT : MASK_LONG;
  assign src  = mode_bits[1:0];
  assign dir  = mode_bits[7:6];

  // Match the event kind against the prescaler clock source
  always_comb begin
    clk_match = 1'b0;
    unique case (req_kind_t'(req.req_type))
      REQ_CPU_WRITE: clk_match = (src == SRC_CPU_WRITE);
      REQ_CPU_CYCLE: clk_match = (src == SRC_CPU_CYCLE);
      REQ_A12_RISE:  clk_match = (src == SRC_A12_RISE);
      REQ_PPU_READ:  clk_match = (src == SRC_PPU_READ);
      default:       clk_match = 1'b0;
    endcase
  end

  // Clock the prescaler first, then apply any register write
  always_comb begin
    enabled_next        = enabled;
    mode_bits_next      = mode_bits;
    prescale_value_next = prescale_value;
    mask_short_next     = mask_short;
    counter_value_next  = counter_value;
    xor_key_next        = xor_key;
    size_byte_next      = size_byte;
    irq_pending_next    = irq_pending;

    if (accept && enabled && clk_match) begin
      unique case (dir)
        DIR_UP: begin
          prescale_value_next = prescale_value + 8'd1;
          if ((prescale_value_next & mask) == 8'h00) begin
            if (!mode_bits[MODE_FREEZE_BIT]) begin
              counter_value_next = counter_value + 8'd1;
            end
            if (counter_value_next == COUNT_UP_HIT) begin
              irq_pending_next = 1'b1;
            end
          end
        end
        DIR_DOWN: begin
          prescale_value_next = prescale_value - 8'd1;
          if ((prescale_value_next & mask) == mask) begin
            if (!mode_bits[MODE_FREEZE_BIT]) begin
              counter_value_next = counter_value - 8'd1;
            end
            if (counter_value_next == COUNT_DOWN_HIT) begin
              irq_pending_next = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    if (accept && (req_kind_t'(req.req_type) == REQ_CPU_WRITE) && req.hits_timer_regs) begin
      unique case (reg_code_t'(req.reg_index))
        REG_ENABLE: begin
          enabled_next = req.write_value[0];
          if (!req.write_value[0]) begin
            prescale_value_next = 8'h00;
            irq_pending_next    = 1'b0;
          end
        end
        REG_MODE: begin
          mode_bits_next  = req.write_value;
          mask_short_next = req.write_value[MODE_SHORT_BIT];
        end
        REG_DISABLE: begin
          enabled_next        = 1'b0;
          prescale_value_next = 8'h00;
          irq_pending_next    = 1'b0;
        end
        REG_ENABLE_B: enabled_next        = 1'b1;
        REG_PRESCALE: prescale_value_next = req.write_value ^ xor_key;
        REG_COUNTER:  counter_value_next  = req.write_value ^ xor_key;
        REG_XOR_KEY:  xor_key_next        = req.write_value;
        REG_SIZE:     size_byte_next      = req.write_value;
        default: ;
      endcase
    end
  end

  // Hold timer state
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled        <= 1'b0;
      mode_bits      <= 8'h00;
      prescale_value <= PRESCALE_RESET;
      mask_short     <= 1'b1;
      counter_value  <= 8'h00;
      xor_key        <= 8'h00;
      size_byte      <= 8'h00;
      irq_pending    <= 1'b0;
    end else begin
      enabled        <= enabled_next;
      mode_bits      <= mode_bits_next;
      prescale_value <= prescale_value_next;
      mask_short     <= mask_short_next;
      counter_value  <= counter_value_next;
      xor_key        <= xor_key_next;
      size_byte      <= size_byte_next;
      irq_pending    <= irq_pending_next;
    end
  end

  // Load the result word on accept, drop it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_irq      <= irq_pending_next;
      out_count    <= counter_value_next;
      out_prescale <= prescale_value_next;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.irq_out       = out_irq;
  assign rsp.count_now     = out_count;
  assign rsp.prescaler_now = out_prescale;

  // The held result always mirrors the live state
  a_result_mirrors_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_count == counter_value) && (out_prescale == prescale_value)
                  && (out_irq == irq_pending))
    else $error("held result differs from timer state");

  // Pending interrupt only rises on an accepted event
  a_irq_rise_on_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(irq_pending) |-> $past(accept))
    else $error("interrupt raised without an event");

  // State holds while no event is taken
  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(counter_value) && $stable(prescale_value) && $stable(enabled))
    else $error("timer state moved without an event");

  // A disabled timer ignores non-write events
  a_disabled_quiet: assert property (@(posedge clk) disable iff (rst)
    accept && !enabled && (req.req_type != REQ_CPU_WRITE)
      |=> $stable(counter_value) && $stable(prescale_value) && $stable(irq_pending))
    else $error("disabled timer changed state");

  // Every accepted event leaves a result
  a_result_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted event produced no result");

endmodule
